// File: hw/rtl/idalloc_pkg.sv
// Shared types and constants for the ID allocator with a free stack.
// Used by every module of the block but idalloc_ram; depends on nothing else.
`default_nettype none

package idalloc_pkg;

  localparam int ID_BITS     = 16;
  localparam int STACK_DEPTH = 256;
  localparam int FIRST_ID    = 1;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int LIMIT_W     = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ID_LIMIT = 1'b0;

  localparam logic ACTION_GET = 1'b0;
  localparam logic ACTION_PUT = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_EXHAUSTED = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic               action;
    logic [ID_BITS-1:0] returned_id;
  } req_t;

  typedef struct packed {
    logic [ID_BITS-1:0] granted_id;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    fresh;
    logic    load_direct;
    logic    load_pop;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic fresh_ok;
    logic rsp_busy;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/idalloc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module idalloc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idalloc_ctrl.sv
// Request sequencer: accepts words, decides push, pop, fresh issue or a full/exhausted status.
// Depends on idalloc_pkg.
`default_nettype none

module idalloc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  input  wire logic                    action,
  input  wire idalloc_pkg::dp_status_t st,
  output logic                         req_stall,
  output idalloc_pkg::cmd_t            cmd
);

  idalloc_pkg::state_t state, state_next;
  logic accept;

  assign req_stall = rst || (state != idalloc_pkg::ST_IDLE) || st.rsp_busy;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = idalloc_pkg::STATUS_OK;
    unique case (state)
      idalloc_pkg::ST_IDLE: begin
        if (accept) begin
          if (action == idalloc_pkg::ACTION_PUT) begin
            cmd.load_direct = 1'b1;
            if (st.full) begin
              cmd.status = idalloc_pkg::STATUS_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (!st.empty) begin
            cmd.pop    = 1'b1;
            state_next = idalloc_pkg::ST_FETCH;
          end else if (st.fresh_ok) begin
            cmd.fresh       = 1'b1;
            cmd.load_direct = 1'b1;
          end else begin
            cmd.load_direct = 1'b1;
            cmd.status      = idalloc_pkg::STATUS_EXHAUSTED;
          end
        end
      end
      idalloc_pkg::ST_FETCH: begin
        cmd.load_pop = 1'b1;
        state_next   = idalloc_pkg::ST_IDLE;
      end
      default: begin
        state_next = idalloc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idalloc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/idalloc_dp.sv
// Datapath: free stack RAM, stack count, fresh counter, limit and result word.
// Depends on idalloc_pkg and idalloc_ram.
`default_nettype none

module idalloc_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire idalloc_pkg::cmd_t                   cmd,
  input  wire logic [idalloc_pkg::ID_BITS-1:0]     returned_id,
  input  wire logic                                cfg_we,
  input  wire logic [idalloc_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  wire logic                                rsp_stall,
  output logic      [idalloc_pkg::LIMIT_W-1:0]     id_limit,
  output idalloc_pkg::dp_status_t                  st,
  output logic                                     rsp_valid,
  output idalloc_pkg::rsp_t                        rsp
);

  logic [idalloc_pkg::CNT_W-1:0]   count, count_next, count_dec;
  logic [idalloc_pkg::ID_BITS-1:0] fresh, fresh_next;
  logic [idalloc_pkg::PTR_W-1:0]   ram_addr;
  logic [idalloc_pkg::ID_BITS-1:0] ram_rdata;
  logic                            rsp_valid_next;
  idalloc_pkg::rsp_t               rsp_next;

  assign count_dec = count - 1'b1;
  assign ram_addr  = cmd.pop ? count_dec[idalloc_pkg::PTR_W-1:0]
                             : count[idalloc_pkg::PTR_W-1:0];

  assign st.empty    = (count == '0);
  assign st.full     = (count == idalloc_pkg::CNT_W'(idalloc_pkg::STACK_DEPTH));
  assign st.fresh_ok = (fresh < id_limit);
  assign st.rsp_busy = rsp_valid && rsp_stall;

  idalloc_ram #(
    .WIDTH(idalloc_pkg::ID_BITS),
    .DEPTH(idalloc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push),
    .re   (cmd.pop),
    .addr (ram_addr),
    .wdata(returned_id),
    .rdata(ram_rdata)
  );

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count_dec;
    end
    fresh_next = cmd.fresh ? fresh + 1'b1 : fresh;

    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    if (cmd.load_direct) begin
      rsp_next.granted_id = cmd.fresh ? fresh : '0;
      rsp_next.status     = cmd.status;
      rsp_valid_next      = 1'b1;
    end else if (cmd.load_pop) begin
      rsp_next.granted_id = ram_rdata;
      rsp_next.status     = idalloc_pkg::STATUS_OK;
      rsp_valid_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fresh     <= idalloc_pkg::ID_BITS'(idalloc_pkg::FIRST_ID);
      id_limit  <= idalloc_pkg::LIMIT_RESET;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      fresh     <= fresh_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_we) begin
        id_limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/id_allocator_free_stack_unit.sv
// Latency: a put, a counter get or an exhausted get gives its result word in the cycle
// after acceptance; a get served from the free stack passes the stack RAM read and ST_FETCH.
// Throughput: one word per cycle while the result word is not stalled; a stack pop
// holds off the next word during ST_FETCH, as the single-port stack RAM read is registered.
// Reset (synchronous, rst high): stack count to zero, fresh counter to FIRST_ID,
// id_limit to 65535; stack RAM contents are kept, no clearing pass.
`default_nettype none

module id_allocator_free_stack_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  req_valid,
  output logic                                       req_stall,
  input  wire idalloc_pkg::req_t                     req,
  output logic                                       rsp_valid,
  input  wire logic                                  rsp_stall,
  output idalloc_pkg::rsp_t                          rsp,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [idalloc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [idalloc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [idalloc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                       pready
);

  idalloc_pkg::cmd_t                   cmd;
  idalloc_pkg::dp_status_t             st;
  logic [idalloc_pkg::LIMIT_W-1:0]     id_limit;
  logic                                reg_sel;
  logic                                cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[idalloc_pkg::APB_ADDR_W-1] == idalloc_pkg::REG_ID_LIMIT);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? idalloc_pkg::APB_DATA_W'(id_limit) : '0;

  idalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .action   (req.action),
    .st       (st),
    .req_stall(req_stall),
    .cmd      (cmd)
  );

  idalloc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .returned_id(req.returned_id),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[idalloc_pkg::LIMIT_W-1:0]),
    .rsp_stall  (rsp_stall),
    .id_limit   (id_limit),
    .st         (st),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// File: hw/rtl/idalloc_checker.sv
// Port-level checks for the ID allocator, bound to the top level.
// Depends on idalloc_pkg and id_allocator_free_stack_unit.
`default_nettype none

module idalloc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_stall,
  input wire idalloc_pkg::req_t req,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire idalloc_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_put_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.action == idalloc_pkg::ACTION_PUT)
    |=> rsp_valid && (rsp.granted_id == '0) &&
        (rsp.status == idalloc_pkg::STATUS_OK || rsp.status == idalloc_pkg::STATUS_FULL))
    else $error("put did not give its result word next cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != idalloc_pkg::STATUS_OK) |-> rsp.granted_id == '0)
    else $error("failed request carries a nonzero ID");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == idalloc_pkg::STATUS_OK ||
                  rsp.status == idalloc_pkg::STATUS_EXHAUSTED ||
                  rsp.status == idalloc_pkg::STATUS_FULL)
    else $error("undefined status code");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result word valid right after reset");

endmodule

bind id_allocator_free_stack_unit idalloc_checker u_idalloc_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire
